FILE: rtl/i2a_pkg.sv
// Package for the integer to ASCII formatter: request and character types,
// field widths, character codes and the digit to character mapping. No dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int unsigned MagW      = 64;
  localparam int unsigned WidthW    = 7;
  localparam int unsigned CharW     = 7;
  localparam int unsigned DecDigits = 20;
  localparam int unsigned DigW      = 4;
  localparam int unsigned MaxWidthDefault = 64;

  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChMinus = 7'h2d;
  localparam logic [CharW-1:0] ChSpace = 7'h20;
  localparam logic [CharW-1:0] ChUpA   = 7'h41;
  localparam logic [CharW-1:0] ChLowA  = 7'h61;

  typedef struct packed {
    logic [MagW-1:0]   magnitude;
    logic              hex_mode;
    logic              negative;
    logic [WidthW-1:0] min_width;
    logic              zero_pad;
    logic              uppercase;
  } in_req_t;

  typedef struct packed {
    logic [CharW-1:0] ascii_char;
    logic             last_char;
  } out_char_t;

  function automatic logic [CharW-1:0] digit_char(input logic [DigW-1:0] d,
                                                  input logic upper);
    logic [CharW-1:0] r;
    if (d < 4'd10) begin
      r = ChZero + {3'b000, d};
    end else begin
      r = (upper ? ChUpA : ChLowA) + {3'b000, d} - 7'd10;
    end
    return r;
  endfunction

endpackage

FILE: rtl/integer_to_ascii_formatter_unit.sv
// Integer to ASCII formatter: bit-serial binary to BCD conversion, leading zero
// scan and a character sequencer with a registered output. Uses i2a_pkg.
// A request is accepted from idle, converted bit by bit in decimal (hex skips the
// conversion), scanned for leading zeros, then sequenced through the sign, pad and
// digit states, one pad or digit character per cycle while the sink takes them;
// one number at a time. Reset (asynchronous, active low) idles.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit #(
  parameter int unsigned MAX_WIDTH = i2a_pkg::MaxWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  i2a_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output i2a_pkg::out_char_t out_o
);
  import i2a_pkg::*;

  localparam int unsigned BcdW = DecDigits * DigW;
  localparam logic [WidthW-1:0] MaxW = WidthW'(MAX_WIDTH);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StConv  = 7'b0000010,
    StScan  = 7'b0000100,
    StSignA = 7'b0001000,
    StPad   = 7'b0010000,
    StSignB = 7'b0100000,
    StDigs  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [MagW-1:0]   mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [5:0]        bit_cnt_q, bit_cnt_d;
  logic [4:0]        nd_q, nd_d;
  logic [WidthW-1:0] pad_q, pad_d;
  logic [WidthW-1:0] width_q, width_d;
  logic              neg_q, neg_d, zpad_q, zpad_d, upper_q, upper_d;
  logic              out_valid_q, out_valid_d;
  out_char_t         out_q, out_d;

  logic              emit_en, emit;
  out_char_t         emit_char;
  logic [BcdW-1:0]   bcd_adj;
  logic [DigW-1:0]   top_dig;
  logic [WidthW-1:0] total;

  assign emit_en = !out_valid_q || out_ready_i;
  assign top_dig = bcd_q[BcdW-1 -: DigW];
  assign total   = WidthW'(nd_q) + WidthW'(neg_q);

  // Add three to every BCD digit of five or more before each shift.
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      if (bcd_q[i*DigW +: DigW] >= 4'd5) begin
        bcd_adj[i*DigW +: DigW] = bcd_q[i*DigW +: DigW] + 4'd3;
      end else begin
        bcd_adj[i*DigW +: DigW] = bcd_q[i*DigW +: DigW];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    nd_d      = nd_q;
    pad_d     = pad_q;
    width_d   = width_q;
    neg_d     = neg_q;
    zpad_d    = zpad_q;
    upper_d   = upper_q;
    emit      = 1'b0;
    emit_char = '{ascii_char: ChSpace, last_char: 1'b0};

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mag_d     = in_req_i.magnitude;
          neg_d     = in_req_i.negative;
          zpad_d    = in_req_i.zero_pad;
          upper_d   = in_req_i.uppercase;
          width_d   = (in_req_i.min_width > MaxW) ? MaxW : in_req_i.min_width;
          nd_d      = 5'(DecDigits);
          bit_cnt_d = '0;
          if (in_req_i.hex_mode) begin
            bcd_d   = {{(BcdW-MagW){1'b0}}, in_req_i.magnitude};
            state_d = StScan;
          end else begin
            bcd_d   = '0;
            state_d = StConv;
          end
        end
      end
      StConv: begin
        bcd_d     = {bcd_adj[BcdW-2:0], mag_q[MagW-1]};
        mag_d     = {mag_q[MagW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 6'd1;
        if (bit_cnt_q == 6'(MagW - 1)) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (top_dig == '0 && nd_q > 5'd1) begin
          bcd_d = {bcd_q[BcdW-DigW-1:0], {DigW{1'b0}}};
          nd_d  = nd_q - 5'd1;
        end else begin
          pad_d   = (width_q > total) ? width_q - total : '0;
          state_d = StSignA;
        end
      end
      StSignA: begin
        // With zero padding the sign leads the pad characters.
        if (!(neg_q && zpad_q)) begin
          state_d = StPad;
        end else if (emit_en) begin
          emit      = 1'b1;
          emit_char = '{ascii_char: ChMinus, last_char: 1'b0};
          state_d   = StPad;
        end
      end
      StPad: begin
        if (pad_q == '0) begin
          state_d = StSignB;
        end else if (emit_en) begin
          emit      = 1'b1;
          emit_char = '{ascii_char: (zpad_q ? ChZero : ChSpace), last_char: 1'b0};
          pad_d     = pad_q - 7'd1;
        end
      end
      StSignB: begin
        if (!(neg_q && !zpad_q)) begin
          state_d = StDigs;
        end else if (emit_en) begin
          emit      = 1'b1;
          emit_char = '{ascii_char: ChMinus, last_char: 1'b0};
          state_d   = StDigs;
        end
      end
      StDigs: begin
        if (emit_en) begin
          emit      = 1'b1;
          emit_char = '{ascii_char: digit_char(top_dig, upper_q),
                        last_char: (nd_q == 5'd1)};
          bcd_d     = {bcd_q[BcdW-DigW-1:0], {DigW{1'b0}}};
          nd_d      = nd_q - 5'd1;
          if (nd_q == 5'd1) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_char;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    bcd_q   <= bcd_d;
    nd_q    <= nd_d;
    pad_q   <= pad_d;
    width_q <= width_d;
    neg_q   <= neg_d;
    zpad_q  <= zpad_d;
    upper_q <= upper_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/i2a_checker.sv
// Port-level checker for the integer to ASCII formatter, bound to the top level.
// Depends on i2a_pkg and on integer_to_ascii_formatter_unit.
`timescale 1ns / 1ps

module i2a_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input i2a_pkg::out_char_t out_o
);
  import i2a_pkg::*;

  logic is_digit, is_letter;
  assign is_digit  = (out_o.ascii_char >= ChZero) && (out_o.ascii_char <= 7'h39);
  assign is_letter = ((out_o.ascii_char >= ChUpA) && (out_o.ascii_char <= 7'h46)) ||
                     ((out_o.ascii_char >= ChLowA) && (out_o.ascii_char <= 7'h66));

  // A character left waiting keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled character changed or dropped");

  // One number at a time: a new request is not taken straight after one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while a number is in progress");

  // Only digits, letters, minus and space are ever produced.
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_digit || is_letter || out_o.ascii_char == ChMinus ||
                    out_o.ascii_char == ChSpace)
    else $error("illegal character produced");

  // The final character of a number is always a decimal or hex digit.
  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last_char |-> is_digit || is_letter)
    else $error("final character is not a digit");

endmodule

bind integer_to_ascii_formatter_unit i2a_checker u_i2a_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
